// ===== src/cwo_pkg.sv =====
package cwo_pkg;

    // Bus event codes
    typedef enum logic [2:0] {
        OP_VIDEO = 3'd0,
        OP_CRAM  = 3'd1,
        OP_MAP   = 3'd2,
        OP_CLOUD = 3'd3,
        OP_TICK  = 3'd4
    } opcode_t;

    // Colors and cloud window
    localparam logic [2:0] COLOR_WHITE   = 3'd7;
    localparam logic [2:0] COLOR_BACK_HI = 3'd6;
    localparam logic [2:0] COLOR_BACK_LO = 3'd2;
    localparam logic [7:0] CLOUD_SPAN    = 8'd64;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_AW + 1;

    // One decoded video write, ready for expansion
    typedef struct packed {
        logic [4:0] x_hi;
        logic [7:0] y;
        logic [7:0] bits;
        logic [2:0] fore;
        logic [2:0] back;
        logic       cloud_en;
        logic [7:0] cloud_even;
        logic [7:0] cloud_odd;
    } entry_t;

endpackage

// ===== src/cwo_ram.sv =====
module cwo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/cwo_front.sv =====
module cwo_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                opcode,
    input  logic [12:0]               address,
    input  logic [7:0]                data,
    input  logic [cwo_pkg::Q_CW-1:0]  q_count,
    output logic                      push,
    output cwo_pkg::entry_t           push_entry
);
    import cwo_pkg::*;

    logic       accept;
    logic       is_video;
    logic       room;
    logic [9:0] tab_idx;
    logic [7:0] y_in;
    logic [7:0] row_dist;
    logic [6:0] cloud_row;
    logic [2:0] cram_rd;
    logic [1:0] map_rd;
    logic [7:0] cloud_even_rd;
    logic [7:0] cloud_odd_rd;

    logic [7:0] cloud_pos_reg, cloud_pos_next;
    logic [2:0] tick_div_reg, tick_div_next;
    logic       s1_valid_reg;
    logic [4:0] s1_x_hi_reg;
    logic [7:0] s1_y_reg;
    logic [7:0] s1_bits_reg;
    logic       s1_near_reg;

    // Hold off video writes while the queue could overflow
    assign is_video = (opcode == OP_VIDEO);
    assign room     = (q_count + Q_CW'(s1_valid_reg)) < Q_CW'(Q_DEPTH);
    assign in_ready = room || !is_video;
    assign accept   = in_valid && in_ready;

    // Table addressing and cloud window
    assign tab_idx   = {address[12:8], address[4:0]};
    assign y_in      = address[12:5];
    assign row_dist  = y_in - cloud_pos_reg;
    assign cloud_row = {~row_dist[5:0], address[0]};

    cwo_ram #(.WIDTH(3), .DEPTH(1024)) u_cram (
        .clk   (clk),
        .we    (accept && opcode == OP_CRAM),
        .waddr (tab_idx),
        .wdata (data[2:0]),
        .raddr (tab_idx),
        .rdata (cram_rd)
    );

    cwo_ram #(.WIDTH(2), .DEPTH(1024)) u_map (
        .clk   (clk),
        .we    (accept && opcode == OP_MAP),
        .waddr (address[9:0]),
        .wdata ({data[3], data[0]}),
        .raddr (tab_idx),
        .rdata (map_rd)
    );

    // Cloud table split into even and odd banks so both nibbles read at once
    cwo_ram #(.WIDTH(8), .DEPTH(128)) u_cloud_even (
        .clk   (clk),
        .we    (accept && opcode == OP_CLOUD && !address[0]),
        .waddr (address[7:1]),
        .wdata (data),
        .raddr (cloud_row),
        .rdata (cloud_even_rd)
    );

    cwo_ram #(.WIDTH(8), .DEPTH(128)) u_cloud_odd (
        .clk   (clk),
        .we    (accept && opcode == OP_CLOUD && address[0]),
        .waddr (address[7:1]),
        .wdata (data),
        .raddr (cloud_row),
        .rdata (cloud_odd_rd)
    );

    // Advance the tick divider and cloud position
    always_comb
    begin
        tick_div_next  = tick_div_reg;
        cloud_pos_next = cloud_pos_reg;
        if (accept && opcode == OP_TICK)
        begin
            tick_div_next = tick_div_reg + 3'd1;
            if (tick_div_reg == 3'd7)
            begin
                cloud_pos_next = cloud_pos_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_div_reg  <= '0;
            cloud_pos_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            tick_div_reg  <= tick_div_next;
            cloud_pos_reg <= cloud_pos_next;
            s1_valid_reg  <= accept && is_video;
        end
    end

    // Capture video write fields while the tables are read
    always_ff @(posedge clk)
    begin
        if (accept && is_video)
        begin
            s1_x_hi_reg <= address[4:0];
            s1_y_reg    <= y_in;
            s1_bits_reg <= data;
            s1_near_reg <= (row_dist <= CLOUD_SPAN);
        end
    end

    // Classify the word and push it to the queue
    assign push = s1_valid_reg;
    always_comb
    begin
        push_entry.x_hi       = s1_x_hi_reg;
        push_entry.y          = s1_y_reg;
        push_entry.bits       = s1_bits_reg;
        push_entry.fore       = ~cram_rd;
        push_entry.back       = map_rd[0] ? COLOR_BACK_HI : COLOR_BACK_LO;
        push_entry.cloud_en   = s1_near_reg && !map_rd[1];
        push_entry.cloud_even = cloud_even_rd;
        push_entry.cloud_odd  = cloud_odd_rd;
    end

endmodule

// ===== src/cwo_queue.sv =====
module cwo_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  cwo_pkg::entry_t          push_entry,
    input  logic                     pop,
    output cwo_pkg::entry_t          head,
    output logic                     not_empty,
    output logic [cwo_pkg::Q_CW-1:0] count
);
    import cwo_pkg::*;

    entry_t            slots [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]   count_reg, count_next;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + Q_CW'(push) - Q_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    assign head      = slots[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

// ===== src/cwo_back.sv =====
module cwo_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            flip,
    input  cwo_pkg::entry_t head,
    input  logic            not_empty,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      pixel_x,
    output logic [7:0]      pixel_y,
    output logic [2:0]      color,
    output logic            last
);
    import cwo_pkg::*;

    logic       advance;
    logic       bit_set;
    logic [7:0] cloud_word;
    logic [1:0] cloud_bit;
    logic [2:0] pix_color;
    logic [7:0] x_raw;

    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] pixel_x_reg;
    logic [7:0] pixel_y_reg;
    logic [2:0] color_reg;
    logic       last_reg;

    // Emit one pixel whenever the output register frees up
    assign advance = not_empty && (!out_valid_reg || out_ready);
    assign pop     = advance && (idx_reg == 3'd7);

    // Pick the pixel color for the current bit
    always_comb
    begin
        bit_set    = head.bits[idx_reg];
        cloud_word = idx_reg[2] ? head.cloud_odd : head.cloud_even;
        cloud_bit  = ~idx_reg[1:0];
        if (bit_set)
        begin
            pix_color = head.fore;
        end
        else if (head.cloud_en && cloud_word[cloud_bit])
        begin
            pix_color = COLOR_WHITE;
        end
        else
        begin
            pix_color = head.back;
        end
        x_raw = {head.x_hi, idx_reg};
    end

    always_comb
    begin
        idx_next       = advance ? idx_reg + 3'd1 : idx_reg;
        out_valid_next = advance || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the output word, mirrored when flip is on
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pixel_x_reg <= flip ? ~x_raw : x_raw;
            pixel_y_reg <= flip ? ~head.y : head.y;
            color_reg   <= pix_color;
            last_reg    <= (idx_reg == 3'd7);
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign color     = color_reg;
    assign last      = last_reg;

endmodule

// ===== src/video_write_cloud_overlay_expand.sv =====
// Channel | Direction | Word fields
// in      | input     | opcode, address, data
// out     | output    | pixel_x, pixel_y, color, last
// cfg     | input     | flip_enable
//
// A video write gives eight pixel words, one per cycle; later writes queue up while
// one is still expanding. The back-part expander emits one pixel a cycle unless the
// queue is empty or the output stalls. Table loads and ticks are accepted even while
// the queue is full. A write's first pixel passes the front stage register, the queue
// and the output register. Reset clears the cloud position, tick divider, flip and
// queue; the tables are undefined until loaded. Output stalls back up into a 4-word queue.
module video_write_cloud_overlay_expand (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [12:0] address,
    input  logic [7:0]  data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  pixel_x,
    output logic [7:0]  pixel_y,
    output logic [2:0]  color,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        flip_enable
);
    import cwo_pkg::*;

    entry_t          push_entry;
    entry_t          head;
    logic            q_push;
    logic            q_pop;
    logic            q_not_empty;
    logic [Q_CW-1:0] q_count;
    logic            flip_reg;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            flip_reg <= flip_enable;
        end
    end

    cwo_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .address    (address),
        .data       (data),
        .q_count    (q_count),
        .push       (q_push),
        .push_entry (push_entry)
    );

    cwo_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head),
        .not_empty  (q_not_empty),
        .count      (q_count)
    );

    cwo_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .flip      (flip_reg),
        .head      (head),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .color     (color),
        .last      (last)
    );

    // Queue never overflows or underflows
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_count < Q_CW'(Q_DEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_count != '0))
        else $error("queue pop while empty");

    // Last marks the final pixel of the byte in either orientation
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (flip_reg ? (pixel_x[2:0] == 3'd0)
                                         : (pixel_x[2:0] == 3'd7))))
        else $error("last flag out of place");

endmodule

// ===== verif/tb_video_write_cloud_overlay_expand.sv =====
module tb_video_write_cloud_overlay_expand;
    import cwo_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TICKS_PER_STEP = 8;
    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_LAST_UNUSED = 3'd7;

    typedef struct {
        logic [2:0]  op;
        logic [12:0] addr;
        logic [7:0]  dat;
        bit          drain;
    } bus_event_t;

    typedef struct {
        logic [7:0] x;
        logic [7:0] y;
        logic [2:0] color;
        logic       last;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  opcode = '0;
    logic [12:0] address = '0;
    logic [7:0]  data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [2:0]  color;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        flip_enable = 1'b0;

    video_write_cloud_overlay_expand dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .address    (address),
        .data       (data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .color      (color),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .flip_enable(flip_enable)
    );

    // Plotter shadow state
    logic [2:0] shade_ram [1024];
    logic [1:0] tint_map [1024];
    logic [7:0] cloud_bits [256];
    logic [7:0] cloud_ofs = '0;
    logic [2:0] tick_count = '0;
    logic       flip_r = 1'b0;

    // Which table entries the generator has already loaded
    bit cram_loaded [1024];
    bit map_loaded [1024];
    bit cloud_loaded [256];
    int gen_ticks = 0;

    bus_event_t pending_events[$];
    pixel_t     expected_pixels[$];

    int  max_gap = 6;
    int  max_stall = 6;
    int  gap_left = 0;
    int  stall_left = 0;
    int  pause;
    bit  sending;
    bus_event_t next_ev;
    pixel_t     want;

    int errors = 0;
    int cycles = 0;
    int events_sent = 0;
    int pixels_seen = 0;
    int cloud_whites = 0;
    int flipped_writes = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string msg);
        $display("mismatch @%0d: %s", cycles, msg);
        errors++;
    endtask

    // Apply one accepted bus event to the shadow state, queue its pixels
    task automatic apply_event(input logic [2:0] op, input logic [12:0] a,
                               input logic [7:0] d);
        logic [7:0] y;
        logic [7:0] x0;
        logic [7:0] x;
        logic [9:0] idx;
        logic [1:0] tint;
        logic [2:0] back;
        logic [2:0] fore;
        logic [2:0] col;
        logic [7:0] row_dist;
        logic [7:0] ofs;
        logic [1:0] bsel;
        bit         in_cloud;
        pixel_t     px;
        events_sent++;
        case (op)
            OP_VIDEO:
            begin
                y = a[12:5];
                x0 = {a[4:0], 3'b000};
                idx = {a[12:8], a[4:0]};
                tint = tint_map[idx];
                back = tint[0] ? COLOR_BACK_HI : COLOR_BACK_LO;
                fore = ~shade_ram[idx];
                row_dist = y - cloud_ofs;
                in_cloud = !tint[1] && (row_dist <= CLOUD_SPAN);
                if (flip_r)
                    flipped_writes++;
                for (int i = 0; i < 8; i++)
                begin
                    x = x0 + 8'(i);
                    if (d[i])
                        col = fore;
                    else if (in_cloud)
                    begin
                        ofs = {~row_dist[5:0], x[3:2]};
                        bsel = ~x[1:0];
                        col = cloud_bits[ofs][bsel] ? COLOR_WHITE : back;
                        if (cloud_bits[ofs][bsel])
                            cloud_whites++;
                    end
                    else
                        col = back;
                    px.x = flip_r ? 8'd255 - x : x;
                    px.y = flip_r ? 8'd255 - y : y;
                    px.color = col;
                    px.last = (i == 7);
                    expected_pixels.push_back(px);
                end
            end
            OP_CRAM:
                shade_ram[{a[12:8], a[4:0]}] = d[2:0];
            OP_MAP:
                tint_map[a[9:0]] = {d[3], d[0]};
            OP_CLOUD:
                cloud_bits[a[7:0]] = d;
            OP_TICK:
            begin
                if (tick_count == 3'(TICKS_PER_STEP - 1))
                begin
                    tick_count = '0;
                    cloud_ofs = cloud_ofs + 8'd1;
                end
                else
                    tick_count = tick_count + 3'd1;
            end
            default:
                ;
        endcase
    endtask

    // Queue one event and note which table entry it fills
    task automatic push_event(input logic [2:0] op, input logic [12:0] a,
                              input logic [7:0] d, input bit drain);
        bus_event_t ev;
        ev.op = op;
        ev.addr = a;
        ev.dat = d;
        ev.drain = drain;
        case (op)
            OP_CRAM:  cram_loaded[{a[12:8], a[4:0]}] = 1'b1;
            OP_MAP:   map_loaded[a[9:0]] = 1'b1;
            OP_CLOUD: cloud_loaded[a[7:0]] = 1'b1;
            OP_TICK:  gen_ticks++;
            default:  ;
        endcase
        pending_events.push_back(ev);
    endtask

    // Queue a video write, loading first any table entry it would read
    task automatic push_video(input logic [12:0] a, input logic [7:0] d, input bit drain);
        logic [9:0] idx;
        logic [7:0] row_dist;
        logic [7:0] ofs;
        idx = {a[12:8], a[4:0]};
        if (!cram_loaded[idx])
            push_event(OP_CRAM, {a[12:8], 3'($urandom), a[4:0]}, 8'($urandom), 1'b0);
        if (!map_loaded[idx])
            push_event(OP_MAP, {3'($urandom), idx}, 8'($urandom), 1'b0);
        row_dist = a[12:5] - 8'(gen_ticks / TICKS_PER_STEP);
        if (row_dist <= CLOUD_SPAN)
        begin
            for (int k = 0; k < 2; k++)
            begin
                ofs = {~row_dist[5:0], a[0], 1'(k)};
                if (!cloud_loaded[ofs])
                    push_event(OP_CLOUD, {5'($urandom), ofs}, 8'($urandom), 1'b0);
            end
        end
        push_event(OP_VIDEO, a, d, drain);
    endtask

    // Queue a mix of random bus events
    task automatic push_random(input int n);
        int r;
        logic [12:0] a;
        bit drain;
        for (int j = 0; j < n; j++)
        begin
            r = $urandom_range(0, 99);
            a = 13'($urandom);
            drain = ($urandom_range(0, 24) == 0);
            if (r < 50)
            begin
                // steer a third of the writes into or just past the cloud window
                if ($urandom_range(0, 2) == 0)
                    a[12:5] = 8'(gen_ticks / TICKS_PER_STEP) + 8'($urandom_range(0, 72));
                push_video(a, 8'($urandom), drain);
            end
            else if (r < 62)
                push_event(OP_CRAM, a, 8'($urandom), drain);
            else if (r < 74)
                push_event(OP_MAP, a, 8'($urandom), drain);
            else if (r < 84)
                push_event(OP_CLOUD, a, 8'($urandom), drain);
            else if (r < 96)
                push_event(OP_TICK, a, 8'($urandom), drain);
            else
                push_event(3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)), a,
                           8'($urandom), drain);
        end
    endtask

    // Hold until everything sent has drawn, then let the pipe settle
    task automatic wait_idle();
        while (pending_events.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the flip register; call right after a rising edge
    task automatic write_flip(input logic v);
        cfg_valid <= 1'b1;
        flip_enable <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        flip_r = v;
    endtask

    // Driver: present queued words, with a random gap before each
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            sending = in_valid;
            if (in_valid && in_ready)
            begin
                apply_event(opcode, address, data);
                sending = 1'b0;
            end
            if (!sending)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_events.size() != 0 &&
                         !(pending_events[0].drain && expected_pixels.size() != 0))
                begin
                    next_ev = pending_events.pop_front();
                    opcode <= next_ev.op;
                    address <= next_ev.addr;
                    data <= next_ev.dat;
                    in_valid <= 1'b1;
                    gap_left <= $urandom_range(0, max_gap);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each pixel word, then stall a random while
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b1;
            stall_left <= 0;
        end
        else if (out_valid && out_ready)
        begin
            pixels_seen++;
            if (expected_pixels.size() == 0)
                report_mismatch($sformatf("pixel word (%0d,%0d) with nothing expected",
                                          pixel_x, pixel_y));
            else
            begin
                want = expected_pixels.pop_front();
                if (pixel_x !== want.x)
                    report_mismatch($sformatf("pixel_x got %0d want %0d", pixel_x, want.x));
                if (pixel_y !== want.y)
                    report_mismatch($sformatf("pixel_y got %0d want %0d", pixel_y, want.y));
                if (color !== want.color)
                    report_mismatch($sformatf("color got %0d want %0d at (%0d,%0d)",
                                              color, want.color, want.x, want.y));
                if (last !== want.last)
                    report_mismatch($sformatf("last got %0d want %0d", last, want.last));
            end
            pause = $urandom_range(0, max_stall);
            if (pause != 0)
            begin
                out_ready <= 1'b0;
                stall_left <= pause;
            end
        end
        else if (!out_ready)
        begin
            if (stall_left <= 1)
                out_ready <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (max_stall != 0 && $urandom_range(0, 15) == 0)
        begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(1, max_stall);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("video_write_cloud_overlay_expand test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_flip(1'b0);

        // Directed: masked color RAM offset, background high with cloud on
        push_event(OP_CRAM, 13'h00e0, 8'hfa, 1'b0);
        push_event(OP_MAP, 13'h1c00, 8'h01, 1'b0);
        push_event(OP_CLOUD, 13'h1ffc, 8'ha5, 1'b0);
        push_event(OP_CLOUD, 13'h00fd, 8'h3c, 1'b0);
        push_video(13'h0000, 8'h00, 1'b0);
        push_video(13'h0000, 8'hff, 1'b0);
        push_video(13'h0000, 8'h5a, 1'b0);
        // Directed: unused opcodes leave no trace
        push_event(OP_FIRST_UNUSED, 13'h1fff, 8'hff, 1'b0);
        push_event(OP_FIRST_UNUSED + 3'd1, 13'h0000, 8'h00, 1'b0);
        push_event(OP_LAST_UNUSED, 13'h1555, 8'haa, 1'b0);
        // Directed: far corner, outside the cloud window
        push_video(13'h1fff, 8'h81, 1'b0);
        // Directed: window edge at distance 64, then just past it
        push_event(OP_MAP, 13'h1500, 8'hf6, 1'b0);
        push_video(13'h0800, 8'h0f, 1'b0);
        push_video(13'h0820, 8'h33, 1'b0);
        // Directed: map bit 3 set blocks the cloud
        push_event(OP_MAP, 13'h0021, 8'h08, 1'b0);
        push_video(13'h0101, 8'h3c, 1'b0);
        // Directed: eight ticks step the cloud, row 0 falls out of the window
        for (int t = 0; t < TICKS_PER_STEP; t++)
            push_event(OP_TICK, 13'($urandom), 8'($urandom), 1'b0);
        push_video(13'h0000, 8'h00, 1'b0);
        wait_idle();

        // Random, mirrored
        write_flip(1'b1);
        push_video(13'($urandom), 8'($urandom), 1'b1);
        push_random(12);
        wait_idle();

        // Random, back to back with no stalls
        write_flip(1'b0);
        max_gap = 0;
        max_stall = 0;
        push_random(12);
        wait_idle();

        // Tick run that steps the cloud twice
        max_gap = 0;
        max_stall = 6;
        for (int t = 0; t < 2 * TICKS_PER_STEP; t++)
            push_event(OP_TICK, 13'($urandom), 8'($urandom), 1'b0);
        push_random(4);
        wait_idle();

        // Random, mirrored again with full idling
        write_flip(1'b1);
        max_gap = 6;
        push_random(12);
        push_video(13'($urandom), 8'($urandom), 1'b1);
        wait_idle();

        $display("sent %0d bus events, checked %0d pixel words (%0d white from cloud)",
                 events_sent, pixels_seen, cloud_whites);
        $display("mirrored writes %0d, cloud position ended at %0d, %0d mismatches",
                 flipped_writes, cloud_ofs, errors);
        if (errors == 0)
            $display("video_write_cloud_overlay_expand test passed");
        else
            $display("video_write_cloud_overlay_expand test failed");
        $finish;
    end

endmodule
